@@ rtl/bpf_pkg.sv @@
`default_nettype none

package bpf_pkg;

	// Command codes of the input channel.
	localparam logic [1:0] CMD_START  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;

	// Frame delimiters.
	localparam logic [15:0] START_WORD = 16'hA0A2;
	localparam logic [15:0] END_WORD   = 16'hB0B3;

	// Operation queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QLVL_W      = 3;

	localparam int SUM_W = 15;

	typedef struct packed {
		logic [1:0] command;
		logic [3:0] msg_type;
		logic       use_type;
		logic [7:0] data_byte;
	} cmd_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
		logic       overflow;
	} pkt_t;

	typedef enum logic [1:0] {
		OP_START,
		OP_APPEND,
		OP_FINISH
	} op_kind_t;

	// One classified operation as it waits in the queue.
	typedef struct packed {
		op_kind_t   kind;
		logic       has_byte;
		logic [7:0] data;
	} op_t;

	typedef struct packed {
		logic [QLVL_W-1:0] level;
		logic              full;
		logic              empty;
	} q_status_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_HEAD,
		SEQ_BODY,
		SEQ_TAIL
	} seq_state_t;

	// One generated packet byte before the store read data is merged in.
	typedef struct packed {
		logic       from_mem;
		logic [7:0] value;
		logic       last;
		logic       ovf;
	} gen_t;

	// Header byte for each message type.
	function automatic logic [7:0] type_header(input logic [3:0] idx);
		logic [7:0] hdr;
		case (idx)
			4'd0:    hdr = 8'h2A;
			4'd1:    hdr = 8'h33;
			4'd2:    hdr = 8'h2F;
			4'd3:    hdr = 8'h2C;
			4'd4:    hdr = 8'h17;
			4'd5:    hdr = 8'h20;
			4'd6:    hdr = 8'h15;
			4'd7:    hdr = 8'h19;
			4'd8:    hdr = 8'h1A;
			4'd9:    hdr = 8'h2B;
			4'd10:   hdr = 8'h18;
			4'd11:   hdr = 8'h16;
			4'd12:   hdr = 8'h40;
			4'd13:   hdr = 8'h41;
			4'd14:   hdr = 8'h42;
			default: hdr = 8'h43;
		endcase
		return hdr;
	endfunction

endpackage

`default_nettype wire

@@ rtl/bpf_front.sv @@
`default_nettype none

module bpf_front (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cmd_valid,
	output logic               cmd_ready,
	input  bpf_pkg::cmd_t      cmd,
	output logic               op_valid,
	input  bpf_pkg::q_status_t q_st,
	output bpf_pkg::op_t       op
);
	import bpf_pkg::*;

	logic v_s1;
	op_t  op_s1;
	op_t  op_dec;
	logic op_ok;

	// Classify the command and resolve the header byte of a start.
	always_comb begin
		op_ok  = 1'b1;
		op_dec = '{kind: OP_APPEND, has_byte: 1'b1, data: cmd.data_byte};
		unique case (cmd.command)
			CMD_START: begin
				op_dec.kind     = OP_START;
				op_dec.has_byte = cmd.use_type;
				op_dec.data     = type_header(cmd.msg_type);
			end
			CMD_APPEND: begin
				op_dec.kind = OP_APPEND;
			end
			CMD_FINISH: begin
				op_dec.kind     = OP_FINISH;
				op_dec.has_byte = 1'b0;
			end
			default: begin
				op_ok = 1'b0;
			end
		endcase
	end

	// The stage drains into the queue whenever the queue has room.
	assign cmd_ready = !v_s1 || !q_st.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd_ready) begin
			v_s1 <= cmd_valid && op_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			op_s1 <= op_dec;
		end
	end

	assign op_valid = v_s1;
	assign op       = op_s1;

endmodule

`default_nettype wire

@@ rtl/bpf_queue.sv @@
`default_nettype none

module bpf_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push_valid,
	input  bpf_pkg::op_t       push_op,
	output bpf_pkg::q_status_t q_st,
	output logic               pop_valid,
	input  wire                pop_ready,
	output bpf_pkg::op_t       pop_op
);
	import bpf_pkg::*;

	op_t               slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QLVL_W-1:0] level_q;
	logic              push;
	logic              pop;

	assign q_st.level = level_q;
	assign q_st.full  = (level_q == QLVL_W'(QUEUE_DEPTH));
	assign q_st.empty = (level_q == '0);

	assign push = push_valid && !q_st.full;
	assign pop  = pop_ready && !q_st.empty;

	assign pop_valid = !q_st.empty;
	assign pop_op    = slot_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

`default_nettype wire

@@ rtl/bpf_back.sv @@
`default_nettype none

module bpf_back #(
	parameter int MAX_PAYLOAD = 32
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           op_valid,
	output logic          op_ready,
	input  bpf_pkg::op_t  op,
	output logic          pkt_valid,
	input  wire           pkt_ready,
	output bpf_pkg::pkt_t pkt
);
	import bpf_pkg::*;

	localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1);
	localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	// Payload store, count, sum and sticky drop flag.
	logic [7:0]       mem_q [MAX_PAYLOAD];
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	logic             drop_q;

	// Snapshot of the packet being emitted.
	logic [CNT_W-1:0] len_q;
	logic [SUM_W-1:0] chk_q;
	logic             ovf_q;

	// Sequencer.
	seq_state_t       state_q;
	seq_state_t       state_d;
	logic [1:0]       sub_q;
	logic [1:0]       sub_d;
	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W-1:0] ptr_d;
	logic             gen_valid;
	gen_t             gen;

	// Byte stage and output register.
	logic             v_s1;
	gen_t             gen_s1;
	logic [7:0]       rd_data_q;
	logic             pkt_v_q;
	pkt_t             pkt_q;

	logic             op_fire;
	logic             has_room;
	logic             wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic             out_adv;
	logic             s1_adv;
	logic [15:0]      len16;

	assign out_adv = !pkt_v_q || pkt_ready;
	assign s1_adv  = !v_s1 || out_adv;

	assign op_ready = (state_q == SEQ_IDLE);
	assign op_fire  = op_valid && op_ready;
	assign has_room = (count_q < CNT_W'(MAX_PAYLOAD));
	assign len16    = 16'(len_q);

	// Store write for a header byte or an appended byte that fits.
	assign wr_en   = op_fire && op.has_byte &&
		((op.kind == OP_START) || ((op.kind == OP_APPEND) && has_room));
	assign wr_addr = (op.kind == OP_START) ? '0 : count_q[ADDR_W-1:0];

	// Next state of the emit sequencer and the byte it produces.
	always_comb begin
		state_d   = state_q;
		sub_d     = sub_q;
		ptr_d     = ptr_q;
		gen_valid = 1'b0;
		gen       = '{from_mem: 1'b0, value: 8'h00, last: 1'b0, ovf: ovf_q};
		unique case (state_q)
			SEQ_IDLE: begin
				if (op_fire && (op.kind == OP_FINISH)) begin
					state_d = SEQ_HEAD;
					sub_d   = 2'd0;
				end
			end
			SEQ_HEAD: begin
				if (s1_adv) begin
					gen_valid = 1'b1;
					sub_d     = sub_q + 2'd1;
					case (sub_q)
						2'd0:    gen.value = START_WORD[15:8];
						2'd1:    gen.value = START_WORD[7:0];
						2'd2:    gen.value = len16[15:8];
						default: gen.value = len16[7:0];
					endcase
					if (sub_q == 2'd3) begin
						ptr_d   = '0;
						state_d = (len_q == '0) ? SEQ_TAIL : SEQ_BODY;
					end
				end
			end
			SEQ_BODY: begin
				if (s1_adv) begin
					gen_valid    = 1'b1;
					gen.from_mem = 1'b1;
					ptr_d        = ptr_q + 1'b1;
					if (ptr_d == len_q) begin
						state_d = SEQ_TAIL;
					end
				end
			end
			SEQ_TAIL: begin
				if (s1_adv) begin
					gen_valid = 1'b1;
					sub_d     = sub_q + 2'd1;
					case (sub_q)
						2'd0:    gen.value = {1'b0, chk_q[SUM_W-1:8]};
						2'd1:    gen.value = chk_q[7:0];
						2'd2:    gen.value = END_WORD[15:8];
						default: gen.value = END_WORD[7:0];
					endcase
					if (sub_q == 2'd3) begin
						gen.last = 1'b1;
						state_d  = SEQ_IDLE;
					end
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			sub_q   <= '0;
			ptr_q   <= '0;
		end else begin
			state_q <= state_d;
			sub_q   <= sub_d;
			ptr_q   <= ptr_d;
		end
	end

	// Execute start, append and finish operations.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			drop_q  <= 1'b0;
		end else if (op_fire) begin
			case (op.kind)
				OP_START: begin
					drop_q  <= 1'b0;
					count_q <= op.has_byte ? CNT_W'(1) : '0;
					sum_q   <= op.has_byte ? SUM_W'(op.data) : '0;
				end
				OP_APPEND: begin
					if (has_room) begin
						count_q <= count_q + 1'b1;
						sum_q   <= sum_q + SUM_W'(op.data);
					end else begin
						drop_q <= 1'b1;
					end
				end
				OP_FINISH: begin
					count_q <= '0;
					sum_q   <= '0;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	// Snapshot taken when a finish starts, as the finish clears the count and sum.
	always_ff @(posedge clk) begin
		if (op_fire && (op.kind == OP_FINISH)) begin
			len_q <= count_q;
			chk_q <= sum_q;
			ovf_q <= drop_q;
		end
	end

	// Payload store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= op.data;
		end
		if (s1_adv && (state_q == SEQ_BODY)) begin
			rd_data_q <= mem_q[ptr_q[ADDR_W-1:0]];
		end
	end

	// Byte stage, aligned with the store read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			pkt_v_q <= 1'b0;
		end else begin
			if (s1_adv) begin
				v_s1 <= gen_valid;
			end
			if (out_adv) begin
				pkt_v_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			gen_s1 <= gen;
		end
		if (out_adv) begin
			pkt_q.out_byte  <= gen_s1.from_mem ? rd_data_q : gen_s1.value;
			pkt_q.last_byte <= gen_s1.last;
			pkt_q.overflow  <= gen_s1.ovf;
		end
	end

	assign pkt_valid = pkt_v_q;
	assign pkt       = pkt_q;

endmodule

`default_nettype wire

@@ rtl/binary_packet_framer.sv @@
`default_nettype none

// Binary packet framer.
// Input channel cmd (cmd_valid/cmd_ready) carries commands: start (clears
// the payload and optionally stores a header byte chosen by msg_type),
// append (stores data_byte) and finish (emits the packet). Output channel
// pkt (pkt_valid/pkt_ready) carries the framed packet one byte per
// transaction: A0 A2, 16-bit length, payload, 15-bit sum, B0 B3, with
// last_byte on the final byte and overflow set if bytes were dropped.
// Commands pass a decode register and a four-entry operation queue before
// the back end takes them. Start and append do not hold the back end, so
// one command per cycle is sustained while the emit sequencer is idle. A
// finish occupies the emit sequencer until all length + 8 bytes are made,
// one byte per cycle when the receiver does not stall, payload bytes from
// the single read port of the payload store; the first byte passes the
// byte stage and the output register before it appears at the output.
// Commands keep being accepted until the queue fills.
// When the receiver stalls, the output register and byte stage hold and
// the sequencer waits. Reset empties the queue and the pipeline and zeroes
// the count, sum and overflow flag; store contents are undefined until
// written.
module binary_packet_framer #(
	parameter int MAX_PAYLOAD = 32
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            cmd_valid,
	output logic           cmd_ready,
	input  bpf_pkg::cmd_t  cmd,
	output logic           pkt_valid,
	input  wire            pkt_ready,
	output bpf_pkg::pkt_t  pkt
);
	import bpf_pkg::*;

	logic      fr_valid;
	op_t       fr_op;
	q_status_t q_st;
	logic      bk_valid;
	logic      bk_ready;
	op_t       bk_op;

	bpf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.op_valid  (fr_valid),
		.q_st      (q_st),
		.op        (fr_op)
	);

	bpf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_op    (fr_op),
		.q_st       (q_st),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_op     (bk_op)
	);

	bpf_back #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (bk_valid),
		.op_ready  (bk_ready),
		.op        (bk_op),
		.pkt_valid (pkt_valid),
		.pkt_ready (pkt_ready),
		.pkt       (pkt)
	);

`ifndef SYNTH
	// The queue level never exceeds its depth.
	a_queue_level: assert property (@(posedge clk) disable iff (!arst_n)
		q_st.level <= QLVL_W'(QUEUE_DEPTH))
		else $error("operation queue level out of range");

	// The last byte of a packet is always the low byte of the end word.
	a_last_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid && pkt.last_byte |-> pkt.out_byte == END_WORD[7:0])
		else $error("last byte is not the end word");

	// Every packet is at least eight bytes, so two last bytes never follow.
	a_last_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid && pkt_ready && pkt.last_byte |=> !(pkt_valid && pkt.last_byte))
		else $error("back-to-back last bytes");
`endif

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
module tb_top;
	import bpf_pkg::*;

	// Command code that the block ignores.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int STORE_DEPTH = 32;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 20;
	localparam int REPORT_MAX = 10;

	// Header byte per message type, entry 0 in the low byte.
	localparam logic [16*8-1:0] HEADER_TABLE = {
		8'h43, 8'h42, 8'h41, 8'h40, 8'h16, 8'h18, 8'h2B, 8'h1A,
		8'h19, 8'h15, 8'h20, 8'h17, 8'h2C, 8'h2F, 8'h33, 8'h2A
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd = '0;
	logic pkt_valid;
	logic pkt_ready = 1'b0;
	pkt_t pkt;

	// Mirror of the framer state.
	logic [7:0] payload_mirror [STORE_DEPTH];
	int unsigned payload_len = 0;
	logic [14:0] payload_sum = '0;
	logic dropped = 1'b0;

	pkt_t pending_bytes [$];
	int errors = 0;
	int sent_items = 0;
	int quiet_cycles = 0;
	bit gaps_on = 1'b1;

	binary_packet_framer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.pkt_valid(pkt_valid),
		.pkt_ready(pkt_ready),
		.pkt(pkt)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Count a failure and report the first few of them.
	task automatic note_error(input string msg);
		errors++;
		if (errors <= REPORT_MAX) begin
			$display("%s", msg);
		end
	endtask

	// Queue one expected packet byte, tagged with the current overflow state.
	task automatic push_byte(input logic [7:0] value, input logic last);
		pkt_t b;
		b.out_byte = value;
		b.last_byte = last;
		b.overflow = dropped;
		pending_bytes.push_back(b);
	endtask

	// Store one payload byte, or drop it when the store is full.
	task automatic store_payload(input logic [7:0] value);
		if (payload_len < STORE_DEPTH) begin
			payload_mirror[payload_len] = value;
			payload_len++;
			payload_sum = payload_sum + 15'(value);
		end else begin
			dropped = 1'b1;
		end
	endtask

	// Update the mirror for one accepted command and queue the bytes it frames.
	task automatic apply_command(input cmd_t c);
		case (c.command)
			CMD_START: begin
				payload_len = 0;
				payload_sum = '0;
				dropped = 1'b0;
				if (c.use_type) begin
					store_payload(HEADER_TABLE[c.msg_type*8 +: 8]);
				end
			end
			CMD_APPEND: begin
				store_payload(c.data_byte);
			end
			CMD_FINISH: begin
				push_byte(START_WORD[15:8], 1'b0);
				push_byte(START_WORD[7:0], 1'b0);
				push_byte(8'(payload_len >> 8), 1'b0);
				push_byte(8'(payload_len), 1'b0);
				for (int i = 0; i < payload_len; i++) begin
					push_byte(payload_mirror[i], 1'b0);
				end
				push_byte({1'b0, payload_sum[14:8]}, 1'b0);
				push_byte(payload_sum[7:0], 1'b0);
				push_byte(END_WORD[15:8], 1'b0);
				push_byte(END_WORD[7:0], 1'b1);
				payload_len = 0;
				payload_sum = '0;
			end
			default: begin
			end
		endcase
	endtask

	// Offer one command, entered and left at a falling edge; valid stays high
	// afterwards so that back-to-back transactions have no gap in between.
	task automatic send_cmd(input logic [1:0] op, input logic [3:0] mtype,
			input logic use_hdr, input logic [7:0] value);
		cmd_t c;
		c.command = op;
		c.msg_type = mtype;
		c.use_type = use_hdr;
		c.data_byte = value;
		while (gaps_on && $urandom_range(99) < 34) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready) begin
			@(posedge clk);
		end
		apply_command(c);
		if (op != CMD_UNUSED) begin
			sent_items++;
		end
		@(negedge clk);
	endtask

	// Stop sending and hold off until every queued packet byte has arrived.
	task automatic wait_for_drain();
		cmd_valid <= 1'b0;
		while (pending_bytes.size() != 0) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// One well-formed packet: optional start, some appends, then finish.
	task automatic send_packet(input int n_data, input bit with_start);
		if (with_start) begin
			send_cmd(CMD_START, 4'($urandom_range(15)), 1'($urandom_range(1)), 8'($urandom));
		end
		repeat (n_data) begin
			send_cmd(CMD_APPEND, 4'($urandom), 1'($urandom), 8'($urandom));
		end
		send_cmd(CMD_FINISH, 4'($urandom), 1'($urandom), 8'($urandom));
	endtask

	// Field extremes, finish and append without start, and the ignored code.
	task automatic test_directed();
		send_cmd(CMD_FINISH, 4'h0, 1'b0, 8'h00);
		send_cmd(CMD_APPEND, 4'h0, 1'b0, 8'h00);
		send_cmd(CMD_APPEND, 4'hF, 1'b1, 8'hFF);
		send_cmd(CMD_FINISH, 4'hF, 1'b1, 8'hFF);
		send_cmd(CMD_START, 4'h0, 1'b1, 8'h00);
		send_cmd(CMD_APPEND, 4'h0, 1'b0, 8'h80);
		send_cmd(CMD_FINISH, 4'h0, 1'b0, 8'h00);
		wait_for_drain();
		send_cmd(CMD_START, 4'hF, 1'b1, 8'hFF);
		send_cmd(CMD_FINISH, 4'h0, 1'b0, 8'h00);
		send_cmd(CMD_START, 4'hA, 1'b0, 8'h55);
		send_cmd(CMD_APPEND, 4'h5, 1'b1, 8'h01);
		send_cmd(CMD_FINISH, 4'h0, 1'b0, 8'h00);
		send_cmd(CMD_UNUSED, 4'hF, 1'b1, 8'hFF);
		send_cmd(CMD_FINISH, 4'h0, 1'b0, 8'h00);
		wait_for_drain();
	endtask

	// Fill the store past its end; the overflow flag must survive a finish
	// and clear on the next start.
	task automatic test_store_full();
		send_cmd(CMD_START, 4'($urandom_range(15)), 1'b1, 8'($urandom));
		repeat (STORE_DEPTH + 1) begin
			send_cmd(CMD_APPEND, 4'($urandom), 1'($urandom), 8'($urandom));
		end
		send_cmd(CMD_FINISH, 4'($urandom), 1'($urandom), 8'($urandom));
		send_cmd(CMD_APPEND, 4'($urandom), 1'($urandom), 8'($urandom));
		send_cmd(CMD_FINISH, 4'($urandom), 1'($urandom), 8'($urandom));
		send_cmd(CMD_START, 4'($urandom_range(15)), 1'b0, 8'($urandom));
		send_cmd(CMD_FINISH, 4'($urandom), 1'($urandom), 8'($urandom));
	endtask

	// Mostly well-formed packets with random content, some noise in between.
	task automatic test_random_packets(input int target);
		int first;
		int n_data;
		first = sent_items;
		while (sent_items - first < target) begin
			if ($urandom_range(99) < 15) begin
				send_cmd(2'($urandom_range(3)), 4'($urandom), 1'($urandom), 8'($urandom));
			end else begin
				n_data = ($urandom_range(4) == 0) ? $urandom_range(STORE_DEPTH + 4)
					: $urandom_range(10);
				send_packet(n_data, $urandom_range(9) != 0);
				if ($urandom_range(19) == 0) begin
					wait_for_drain();
				end
			end
		end
	endtask

	// Back-to-back transactions on both channels with no gaps at all.
	task automatic test_no_gaps(input int target);
		int first;
		first = sent_items;
		gaps_on = 1'b0;
		while (sent_items - first < target) begin
			send_packet($urandom_range(12), 1'b1);
		end
		wait_for_drain();
		gaps_on = 1'b1;
	endtask

	// Receiver stalls at random while gaps are enabled.
	always @(negedge clk) begin
		pkt_ready <= !(gaps_on && $urandom_range(99) < 34);
	end

	// Compare each packet byte with the oldest expectation.
	always @(posedge clk) begin : check_bytes
		pkt_t want;
		if (arst_n && pkt_valid && pkt_ready) begin
			if (pending_bytes.size() == 0) begin
				note_error($sformatf("unexpected packet byte %h last %b overflow %b",
					pkt.out_byte, pkt.last_byte, pkt.overflow));
			end else begin
				want = pending_bytes.pop_front();
				if (pkt.out_byte !== want.out_byte) begin
					note_error($sformatf("out_byte: expected %h, got %h",
						want.out_byte, pkt.out_byte));
				end
				if (pkt.last_byte !== want.last_byte) begin
					note_error($sformatf("last_byte: expected %b, got %b (byte %h)",
						want.last_byte, pkt.last_byte, want.out_byte));
				end
				if (pkt.overflow !== want.overflow) begin
					note_error($sformatf("overflow: expected %b, got %b (byte %h)",
						want.overflow, pkt.overflow, want.out_byte));
				end
			end
		end
	end

	// End the run if no transaction happens on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && cmd_ready) || (pkt_valid && pkt_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_store_full();
		test_random_packets(130);
		test_no_gaps(40);
		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
